>>> rtl/hwps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hwps_pkg;

   // mixer and generator constants
   localparam logic [63:0] MIX_C1          = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_C2          = 64'h94d049bb133111eb;
   localparam logic [63:0] MIX_GAMMA       = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] ZERO_SEED_STATE = 64'h13579bdf13579bdf;

   // counting and rate limits
   localparam logic [16:0] HARD_CAP   = 17'd100000;
   localparam logic [16:0] COUNT_MAX  = 17'd131071;
   localparam logic [15:0] RATE_FLOOR = 16'd3;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLOBAL_SEED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_CAP   = 2'd1;

   // result status codes
   localparam logic [1:0] RSP_OK       = 2'd0;
   localparam logic [1:0] RSP_OVER_CAP = 2'd1;
   localparam logic [1:0] RSP_NO_POOL  = 2'd2;

   typedef struct packed {
      logic               kind;
      logic [3:0]         entry_index;
      logic [15:0]        entry_weight;
      logic               entry_has_asset;
      logic [15:0]        rate_min_in;
      logic [15:0]        rate_max_in;
      logic signed [31:0] pt_seed;
      logic               first_of_batch;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  chosen_entry;
      logic [15:0] rate_q88;
   } rsp_word_type;

   // one stored pool entry
   typedef struct packed {
      logic        has_asset;
      logic [15:0] weight;
      logic [15:0] rate_min;
      logic [15:0] rate_max;
   } pool_entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD_RD, S_LOAD_WR, S_COUNT, S_CHECK,
      S_XS30, S_M_LL, S_M_HL, S_M_LH, S_M_FIN, S_XS27, S_XS31,
      S_TRUNC, S_SEEDST, S_T1, S_T2, S_T3, S_SCAN_INIT, S_SCAN,
      S_RCHK, S_R1, S_R2, S_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_LOAD_RD, OP_LOAD_WR, OP_COUNT, OP_SEED,
      OP_XS30, OP_XS27, OP_XS31, OP_MUL_LL, OP_MUL_HL, OP_MUL_LH, OP_MUL_FIN,
      OP_TRUNC, OP_SEEDST, OP_T1, OP_T2, OP_T3, OP_SCAN_INIT, OP_SCAN,
      OP_STEP, OP_R1, OP_R2, OP_EMIT
   } dp_op_type;

   typedef enum logic [1:0] {
      K_C1, K_C2, K_GAMMA
   } mul_const_type;

   typedef enum logic [1:0] {
      PH_HASH, PH_DRAW1, PH_DRAW2
   } mix_phase_type;

   typedef struct packed {
      dp_op_type     op;
      mul_const_type cnst;
      logic [1:0]    status;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic over_cap;
      logic found;
      logic span_nz;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> rtl/hashed_weighted_pool_sampler.sv
// load word: busy through the read and write states after start; no result
// point word: flagged ones answer after the count and check states; decorated ones run
//   the hash, a first draw and the slot scan up to the picked slot, plus a second draw
//   when the rate range is open; 64-bit products come from the shared 32x32 multiplier
// one word at a time; the result strobe lasts one cycle and cannot be stalled
// synchronous reset clears the pool, the point count and the registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module hashed_weighted_pool_sampler #(
   parameter int unsigned POOL_DEPTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  hwps_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   output hwps_pkg::rsp_word_type rsp_word,
   input  wire                    csr_we,
   input  wire [hwps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [31:0]             csr_wdata
);

   hwps_pkg::dp_cmd_type  cmd;
   hwps_pkg::dp_stat_type stat;

   // sequencer
   hwps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_word.kind),
      .busy     (busy),
      .cmd      (cmd),
      .stat     (stat)
   );

   // pool, mixer and scan datapath
   hwps_dp #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

>>> rtl/hwps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hwps_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire                  req_kind,
   output logic                 busy,
   output hwps_pkg::dp_cmd_type cmd,
   input  hwps_pkg::dp_stat_type stat
);

   hwps_pkg::state_type     state_ff, state_in;
   hwps_pkg::mix_phase_type phase_ff, phase_in;
   hwps_pkg::mul_const_type mulk_ff, mulk_in;

   assign busy = (state_ff != hwps_pkg::S_IDLE);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hwps_pkg::S_IDLE;
         phase_ff <= hwps_pkg::PH_HASH;
         mulk_ff  <= hwps_pkg::K_C1;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         mulk_ff  <= mulk_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      mulk_in    = mulk_ff;
      cmd.op     = hwps_pkg::OP_NONE;
      cmd.cnst   = mulk_ff;
      cmd.status = hwps_pkg::RSP_OK;
      case (state_ff)
         hwps_pkg::S_IDLE: begin
            if (start) begin
               cmd.op   = hwps_pkg::OP_CAPTURE;
               state_in = req_kind ? hwps_pkg::S_COUNT : hwps_pkg::S_LOAD_RD;
            end
         end
         hwps_pkg::S_LOAD_RD: begin
            cmd.op   = hwps_pkg::OP_LOAD_RD;
            state_in = hwps_pkg::S_LOAD_WR;
         end
         hwps_pkg::S_LOAD_WR: begin
            cmd.op   = hwps_pkg::OP_LOAD_WR;
            state_in = hwps_pkg::S_IDLE;
         end
         hwps_pkg::S_COUNT: begin
            cmd.op   = hwps_pkg::OP_COUNT;
            state_in = hwps_pkg::S_CHECK;
         end
         hwps_pkg::S_CHECK: begin
            if (stat.empty) begin
               cmd.op     = hwps_pkg::OP_EMIT;
               cmd.status = hwps_pkg::RSP_NO_POOL;
               state_in   = hwps_pkg::S_IDLE;
            end else if (stat.over_cap) begin
               cmd.op     = hwps_pkg::OP_EMIT;
               cmd.status = hwps_pkg::RSP_OVER_CAP;
               state_in   = hwps_pkg::S_IDLE;
            end else begin
               cmd.op   = hwps_pkg::OP_SEED;
               phase_in = hwps_pkg::PH_HASH;
               state_in = hwps_pkg::S_XS30;
            end
         end
         hwps_pkg::S_XS30: begin
            cmd.op   = hwps_pkg::OP_XS30;
            mulk_in  = hwps_pkg::K_C1;
            state_in = hwps_pkg::S_M_LL;
         end
         hwps_pkg::S_XS27: begin
            cmd.op   = hwps_pkg::OP_XS27;
            mulk_in  = hwps_pkg::K_C2;
            state_in = hwps_pkg::S_M_LL;
         end
         hwps_pkg::S_TRUNC: begin
            cmd.op   = hwps_pkg::OP_TRUNC;
            mulk_in  = hwps_pkg::K_GAMMA;
            state_in = hwps_pkg::S_M_LL;
         end
         hwps_pkg::S_M_LL: begin
            cmd.op   = hwps_pkg::OP_MUL_LL;
            state_in = hwps_pkg::S_M_HL;
         end
         hwps_pkg::S_M_HL: begin
            cmd.op   = hwps_pkg::OP_MUL_HL;
            state_in = hwps_pkg::S_M_LH;
         end
         hwps_pkg::S_M_LH: begin
            cmd.op   = hwps_pkg::OP_MUL_LH;
            state_in = hwps_pkg::S_M_FIN;
         end
         hwps_pkg::S_M_FIN: begin
            cmd.op = hwps_pkg::OP_MUL_FIN;
            case (mulk_ff)
               hwps_pkg::K_C1:    state_in = hwps_pkg::S_XS27;
               hwps_pkg::K_C2:    state_in = hwps_pkg::S_XS31;
               default:           state_in = hwps_pkg::S_SEEDST;
            endcase
         end
         hwps_pkg::S_XS31: begin
            cmd.op = hwps_pkg::OP_XS31;
            case (phase_ff)
               hwps_pkg::PH_HASH:  state_in = hwps_pkg::S_TRUNC;
               hwps_pkg::PH_DRAW1: state_in = hwps_pkg::S_T1;
               default:            state_in = hwps_pkg::S_R1;
            endcase
         end
         hwps_pkg::S_SEEDST: begin
            cmd.op   = hwps_pkg::OP_SEEDST;
            phase_in = hwps_pkg::PH_DRAW1;
            state_in = hwps_pkg::S_XS30;
         end
         hwps_pkg::S_T1: begin
            cmd.op   = hwps_pkg::OP_T1;
            state_in = hwps_pkg::S_T2;
         end
         hwps_pkg::S_T2: begin
            cmd.op   = hwps_pkg::OP_T2;
            state_in = hwps_pkg::S_T3;
         end
         hwps_pkg::S_T3: begin
            cmd.op   = hwps_pkg::OP_T3;
            state_in = hwps_pkg::S_SCAN_INIT;
         end
         hwps_pkg::S_SCAN_INIT: begin
            cmd.op   = hwps_pkg::OP_SCAN_INIT;
            state_in = hwps_pkg::S_SCAN;
         end
         hwps_pkg::S_SCAN: begin
            if (stat.found) begin
               state_in = hwps_pkg::S_RCHK;
            end else begin
               cmd.op = hwps_pkg::OP_SCAN;
            end
         end
         hwps_pkg::S_RCHK: begin
            if (stat.span_nz) begin
               cmd.op   = hwps_pkg::OP_STEP;
               phase_in = hwps_pkg::PH_DRAW2;
               state_in = hwps_pkg::S_XS30;
            end else begin
               cmd.op   = hwps_pkg::OP_EMIT;
               state_in = hwps_pkg::S_IDLE;
            end
         end
         hwps_pkg::S_R1: begin
            cmd.op   = hwps_pkg::OP_R1;
            state_in = hwps_pkg::S_R2;
         end
         hwps_pkg::S_R2: begin
            cmd.op   = hwps_pkg::OP_R2;
            state_in = hwps_pkg::S_EMIT;
         end
         hwps_pkg::S_EMIT: begin
            cmd.op   = hwps_pkg::OP_EMIT;
            state_in = hwps_pkg::S_IDLE;
         end
         default: begin
            state_in = hwps_pkg::S_IDLE;
         end
      endcase
   end

   // a result always ends the item
   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == hwps_pkg::OP_EMIT) |=> (state_ff == hwps_pkg::S_IDLE))
      else $error("emit not followed by idle");

   // a new item is only taken from idle
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == hwps_pkg::OP_CAPTURE) |-> (start && !busy))
      else $error("capture outside idle");

endmodule

`default_nettype wire

>>> rtl/hwps_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module hwps_dp #(
   parameter int unsigned POOL_DEPTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  hwps_pkg::req_word_type req_word,
   input  wire                    csr_we,
   input  wire [hwps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [31:0]             csr_wdata,
   input  hwps_pkg::dp_cmd_type   cmd,
   output hwps_pkg::dp_stat_type  stat,
   output logic                   rsp_valid,
   output hwps_pkg::rsp_word_type rsp_word
);

   localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int unsigned TW = 16 + AW;

   // pool memory and per-entry valid bits
   hwps_pkg::pool_entry_type mem [0:POOL_DEPTH-1];
   logic [POOL_DEPTH-1:0]    valid_ff, valid_in;

   // control registers
   logic [31:0]   gseed_ff, gseed_in;
   logic [16:0]   cap_ff, cap_in;
   logic [16:0]   points_ff, points_in;
   logic [TW-1:0] total_ff, total_in;
   logic          empty_ff, empty_in;
   logic          over_ff, over_in;
   logic          found_ff, found_in;
   logic          rdv_ff, rdv_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   hwps_pkg::req_word_type   req_ff, req_in;
   logic [63:0]              z_ff, z_in;
   logic [63:0]              st_ff, st_in;
   logic [63:0]              prod_ff, prod_in;
   logic [63:0]              acc_ff, acc_in;
   logic [31:0]              target_ff, target_in;
   logic [TW-1:0]            run_ff, run_in;
   logic [AW-1:0]            sidx_ff, sidx_in;
   logic [AW-1:0]            pidx_ff, pidx_in;
   logic [AW-1:0]            pick_ff, pick_in;
   logic [15:0]              lo_ff, lo_in;
   logic [15:0]              span_ff, span_in;
   logic [15:0]              rate_ff, rate_in;
   hwps_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;
   hwps_pkg::pool_entry_type rd_data_ff;
   logic                     rd_valid_ff;

   // combinational helpers
   logic [AW+3:0]            idx_wide;
   logic [AW-1:0]            load_addr;
   logic                     load_in_range;
   logic [AW-1:0]            rd_addr;
   logic                     rd_in_range;
   hwps_pkg::pool_entry_type new_entry;
   logic [15:0]              old_eff, new_eff, rd_eff;
   logic [63:0]              cnst;
   logic [31:0]              mul_a, mul_b;
   logic [63:0]              mul_p;
   logic [16:0]              cnt_before, cap_eff;
   logic [63:0]              seed_base, st_step, t3_sum;
   logic [TW-1:0]            run_new;
   logic [15:0]              lo_pick, hi_pick;
   logic [AW+3:0]            pick_wide;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign stat.empty    = empty_ff;
   assign stat.over_cap = over_ff;
   assign stat.found    = found_ff;
   assign stat.span_nz  = (span_ff != 16'd0);

   // load slot decode
   assign idx_wide      = (AW + 4)'(req_ff.entry_index);
   assign load_addr     = idx_wide[AW-1:0];
   assign load_in_range = (32'(req_ff.entry_index) < 32'(POOL_DEPTH));
   assign rd_addr       = (cmd.op == hwps_pkg::OP_LOAD_RD) ? load_addr : sidx_ff;
   assign rd_in_range   = (32'(rd_addr) < 32'(POOL_DEPTH));

   assign new_entry.has_asset = req_ff.entry_has_asset;
   assign new_entry.weight    = req_ff.entry_weight;
   assign new_entry.rate_min  = req_ff.rate_min_in;
   assign new_entry.rate_max  = req_ff.rate_max_in;

   // weight that counts toward the total
   assign rd_eff  = (rd_valid_ff && rd_data_ff.has_asset) ? rd_data_ff.weight : 16'd0;
   assign old_eff = rd_eff;
   assign new_eff = req_ff.entry_has_asset ? req_ff.entry_weight : 16'd0;

   // shared 32x32 multiplier with operand selection
   always_comb begin
      case (cmd.cnst)
         hwps_pkg::K_C1:    cnst = hwps_pkg::MIX_C1;
         hwps_pkg::K_C2:    cnst = hwps_pkg::MIX_C2;
         default:           cnst = hwps_pkg::MIX_GAMMA;
      endcase
      case (cmd.op)
         hwps_pkg::OP_MUL_HL: begin
            mul_a = z_ff[63:32];
            mul_b = cnst[31:0];
         end
         hwps_pkg::OP_MUL_LH: begin
            mul_a = z_ff[31:0];
            mul_b = cnst[63:32];
         end
         hwps_pkg::OP_T1: begin
            mul_a = z_ff[42:11];
            mul_b = 32'(total_ff);
         end
         hwps_pkg::OP_T2: begin
            mul_a = {11'd0, z_ff[63:43]};
            mul_b = 32'(total_ff);
         end
         hwps_pkg::OP_R1: begin
            mul_a = {16'd0, z_ff[63:48]};
            mul_b = {16'd0, span_ff};
         end
         default: begin
            mul_a = z_ff[31:0];
            mul_b = cnst[31:0];
         end
      endcase
   end

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   // batch count and cap
   assign cnt_before = req_ff.first_of_batch ? 17'd0 : points_ff;
   assign cap_eff    = (cap_ff < hwps_pkg::HARD_CAP) ? cap_ff : hwps_pkg::HARD_CAP;

   // generator seeding and stepping
   assign seed_base = (z_ff == 64'd0) ? hwps_pkg::ZERO_SEED_STATE : z_ff;
   assign st_step   = ((cmd.op == hwps_pkg::OP_SEEDST) ? seed_base : st_ff)
                      + hwps_pkg::MIX_GAMMA;
   assign t3_sum    = (prod_ff << 11) + (acc_ff >> 21);

   // scan arithmetic
   assign run_new = run_ff + TW'(rd_eff);
   assign lo_pick = (rd_data_ff.rate_min < hwps_pkg::RATE_FLOOR) ?
                    hwps_pkg::RATE_FLOOR : rd_data_ff.rate_min;
   assign hi_pick = (rd_data_ff.rate_max < lo_pick) ? lo_pick : rd_data_ff.rate_max;

   assign pick_wide = (AW + 4)'(pick_ff);

   // next-state logic of the datapath
   always_comb begin
      valid_in     = valid_ff;
      gseed_in     = gseed_ff;
      cap_in       = cap_ff;
      points_in    = points_ff;
      total_in     = total_ff;
      empty_in     = empty_ff;
      over_in      = over_ff;
      found_in     = found_ff;
      rdv_in       = 1'b0;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      z_in         = z_ff;
      st_in        = st_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      target_in    = target_ff;
      run_in       = run_ff;
      sidx_in      = sidx_ff;
      pidx_in      = pidx_ff;
      pick_in      = pick_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      rate_in      = rate_ff;
      rsp_word_in  = rsp_word_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            hwps_pkg::CSR_GLOBAL_SEED: gseed_in = csr_wdata;
            hwps_pkg::CSR_POINT_CAP:   cap_in   = csr_wdata[16:0];
            default: begin
            end
         endcase
      end

      case (cmd.op)
         hwps_pkg::OP_CAPTURE: req_in = req_word;
         hwps_pkg::OP_LOAD_WR: begin
            if (load_in_range) begin
               valid_in[load_addr] = 1'b1;
               total_in = total_ff - TW'(old_eff) + TW'(new_eff);
            end
         end
         hwps_pkg::OP_COUNT: begin
            points_in = (cnt_before < hwps_pkg::COUNT_MAX) ? cnt_before + 17'd1
                                                           : cnt_before;
            empty_in  = (total_ff == '0);
            over_in   = (cnt_before >= cap_eff);
         end
         hwps_pkg::OP_SEED:    z_in = {gseed_ff, req_ff.pt_seed};
         hwps_pkg::OP_XS30:    z_in = z_ff ^ (z_ff >> 30);
         hwps_pkg::OP_XS27:    z_in = z_ff ^ (z_ff >> 27);
         hwps_pkg::OP_XS31:    z_in = z_ff ^ (z_ff >> 31);
         hwps_pkg::OP_MUL_LL:  prod_in = mul_p;
         hwps_pkg::OP_MUL_HL: begin
            acc_in  = prod_ff;
            prod_in = mul_p;
         end
         hwps_pkg::OP_MUL_LH: begin
            acc_in  = acc_ff + {prod_ff[31:0], 32'd0};
            prod_in = mul_p;
         end
         hwps_pkg::OP_MUL_FIN: z_in = acc_ff + {prod_ff[31:0], 32'd0};
         hwps_pkg::OP_TRUNC:   z_in = {32'd0, z_ff[31:0]};
         hwps_pkg::OP_SEEDST,
         hwps_pkg::OP_STEP: begin
            st_in = st_step;
            z_in  = st_step;
         end
         hwps_pkg::OP_T1:      prod_in = mul_p;
         hwps_pkg::OP_T2: begin
            acc_in  = prod_ff;
            prod_in = mul_p;
         end
         hwps_pkg::OP_T3:      target_in = t3_sum[63:32];
         hwps_pkg::OP_SCAN_INIT: begin
            sidx_in  = '0;
            run_in   = '0;
            found_in = 1'b0;
         end
         hwps_pkg::OP_SCAN: begin
            sidx_in = sidx_ff + AW'(1);
            pidx_in = sidx_ff;
            rdv_in  = 1'b1;
            // evaluate the entry read in the previous cycle
            if (rdv_ff && !found_ff && (rd_eff != 16'd0)) begin
               run_in = run_new;
               if (32'(run_new) > target_ff) begin
                  found_in = 1'b1;
                  pick_in  = pidx_ff;
                  lo_in    = lo_pick;
                  span_in  = hi_pick - lo_pick;
                  rate_in  = lo_pick;
               end
            end
         end
         hwps_pkg::OP_R1:      prod_in = mul_p;
         hwps_pkg::OP_R2:      rate_in = lo_ff + prod_ff[31:16];
         hwps_pkg::OP_EMIT: begin
            rsp_valid_in       = 1'b1;
            rsp_word_in.status = cmd.status;
            if (cmd.status == hwps_pkg::RSP_OK) begin
               rsp_word_in.chosen_entry = pick_wide[3:0];
               rsp_word_in.rate_q88     = rate_ff;
            end else begin
               rsp_word_in.chosen_entry = 4'd0;
               rsp_word_in.rate_q88     = 16'd0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         gseed_ff     <= 32'd0;
         cap_ff       <= hwps_pkg::HARD_CAP;
         points_ff    <= 17'd0;
         total_ff     <= '0;
         empty_ff     <= 1'b0;
         over_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         gseed_ff     <= gseed_in;
         cap_ff       <= cap_in;
         points_ff    <= points_in;
         total_ff     <= total_in;
         empty_ff     <= empty_in;
         over_ff      <= over_in;
         found_ff     <= found_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      z_ff        <= z_in;
      st_ff       <= st_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      target_ff   <= target_in;
      run_ff      <= run_in;
      sidx_ff     <= sidx_in;
      pidx_ff     <= pidx_in;
      pick_ff     <= pick_in;
      lo_ff       <= lo_in;
      span_ff     <= span_in;
      rate_ff     <= rate_in;
      rsp_word_ff <= rsp_word_in;
   end

   // pool memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if ((cmd.op == hwps_pkg::OP_LOAD_WR) && load_in_range) begin
         mem[load_addr] <= new_entry;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= rd_in_range ? valid_ff[rd_addr] : 1'b0;
   end

   // a result word is a single-cycle strobe
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   // a decorated point never falls below the rate floor
   a_rate_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.status == hwps_pkg::RSP_OK))
      |-> (rsp_word_ff.rate_q88 >= hwps_pkg::RATE_FLOOR))
      else $error("decorated rate below floor");

   // empty-pool flag agrees with the running total
   a_no_pool: assert property (@(posedge clock) disable iff (reset)
      ((cmd.op == hwps_pkg::OP_EMIT) && (cmd.status == hwps_pkg::RSP_NO_POOL))
      |-> (total_ff == '0))
      else $error("no-pool status with nonzero total");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_POINT = 1'b1;
   localparam int   DEPTH      = 16;
   localparam int   SETTLE     = 80;
   localparam longint CYCLE_LIMIT = 4000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   hwps_pkg::req_word_type req_word = '0;
   logic         rsp_valid;
   hwps_pkg::rsp_word_type rsp_word;
   logic         csr_we = 1'b0;
   logic [hwps_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   // words waiting to be sent and results waiting to arrive
   hwps_pkg::req_word_type word_q[$];
   hwps_pkg::rsp_word_type sample_q[$];

   // shadow of the block state
   logic [15:0] sh_weight[DEPTH];
   logic        sh_asset[DEPTH];
   logic [15:0] sh_rmin[DEPTH];
   logic [15:0] sh_rmax[DEPTH];
   logic [16:0] sh_seen;
   logic [31:0] sh_seed;
   logic [16:0] sh_cap;

   int     idle_pct = 0;
   int     errors = 0;
   longint cycles = 0;

   hashed_weighted_pool_sampler u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // splitmix64 finalizer
   function automatic logic [63:0] finalize(input logic [63:0] z);
      z = (z ^ (z >> 30)) * hwps_pkg::MIX_C1;
      z = (z ^ (z >> 27)) * hwps_pkg::MIX_C2;
      return z ^ (z >> 31);
   endfunction

   // work out the sample result of one accepted word
   task automatic sample_word(input hwps_pkg::req_word_type w);
      logic [19:0]  total;
      logic [19:0]  run;
      logic [63:0]  h;
      logic [63:0]  st;
      logic [63:0]  d;
      logic [127:0] prod;
      logic [63:0]  span;
      logic [16:0]  count_before;
      logic [16:0]  cap;
      logic [15:0]  lo;
      logic [15:0]  hi;
      int           pick;
      bit           found;
      hwps_pkg::rsp_word_type r;
      if (w.kind == KIND_LOAD) begin
         sh_weight[w.entry_index] = w.entry_weight;
         sh_asset[w.entry_index]  = w.entry_has_asset;
         sh_rmin[w.entry_index]   = w.rate_min_in;
         sh_rmax[w.entry_index]   = w.rate_max_in;
         return;
      end
      if (w.first_of_batch) sh_seen = '0;
      count_before = sh_seen;
      if (sh_seen < hwps_pkg::COUNT_MAX) sh_seen = sh_seen + 17'd1;
      r = '0;
      total = '0;
      for (int i = 0; i < DEPTH; i++)
         if (sh_weight[i] != 0 && sh_asset[i]) total = total + sh_weight[i];
      cap = (sh_cap < hwps_pkg::HARD_CAP) ? sh_cap : hwps_pkg::HARD_CAP;
      if (total == 0) begin
         r.status = hwps_pkg::RSP_NO_POOL;
      end else if (count_before >= cap) begin
         r.status = hwps_pkg::RSP_OVER_CAP;
      end else begin
         h = finalize({sh_seed, w.pt_seed}) & 64'hFFFF_FFFF;
         st = h * hwps_pkg::MIX_GAMMA;
         if (st == 0) st = hwps_pkg::ZERO_SEED_STATE;
         // weighted pick from the first draw
         st = st + hwps_pkg::MIX_GAMMA;
         d = finalize(st) >> 11;
         prod = 128'(d) * 128'(total);
         run = '0;
         pick = 0;
         found = 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            if (!found && sh_weight[i] != 0 && sh_asset[i]) begin
               run = run + sh_weight[i];
               pick = i;
               if (128'(run) > (prod >> 53)) found = 1'b1;
            end
         end
         // rate jitter from the second draw
         lo = (sh_rmin[pick] < hwps_pkg::RATE_FLOOR) ? hwps_pkg::RATE_FLOOR : sh_rmin[pick];
         hi = (sh_rmax[pick] < lo) ? lo : sh_rmax[pick];
         if (hi > lo) begin
            st = st + hwps_pkg::MIX_GAMMA;
            d = finalize(st) >> 48;
            span = d * 64'(hi - lo);
            r.rate_q88 = lo + span[31:16];
         end else begin
            r.rate_q88 = lo;
         end
         r.status = hwps_pkg::RSP_OK;
         r.chosen_entry = pick[3:0];
      end
      sample_q.push_back(r);
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
      errors++;
   endtask

   // driver: start stays high while words are queued and the sender is not idling
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            sample_word(req_word);
            void'(word_q.pop_front());
         end
         if (!start || !busy) begin
            if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               start <= 1'b1;
               req_word <= word_q[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed word is checked against the oldest sample
   always @(posedge clock) begin
      hwps_pkg::rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (sample_q.size() == 0) begin
            report("result with none pending", 32'(rsp_word), 32'd0);
         end else begin
            want = sample_q.pop_front();
            if (rsp_word.status !== want.status)
               report("status", 32'(rsp_word.status), 32'(want.status));
            if (rsp_word.chosen_entry !== want.chosen_entry)
               report("chosen_entry", 32'(rsp_word.chosen_entry), 32'(want.chosen_entry));
            if (rsp_word.rate_q88 !== want.rate_q88)
               report("rate_q88", 32'(rsp_word.rate_q88), 32'(want.rate_q88));
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic wait_idle();
      @(posedge clock);
      while (word_q.size() != 0 || start || sample_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [hwps_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] data);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == hwps_pkg::CSR_GLOBAL_SEED) sh_seed = data;
      else if (idx == hwps_pkg::CSR_POINT_CAP) sh_cap = data[16:0];
   endtask

   // load word, unused fields carry noise
   task automatic add_load(input int idx, input int wgt, input bit asset,
                           input int rmin, input int rmax);
      hwps_pkg::req_word_type w;
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      w = noise[$bits(hwps_pkg::req_word_type)-1:0];
      w.kind = KIND_LOAD;
      w.entry_index = idx[3:0];
      w.entry_weight = wgt[15:0];
      w.entry_has_asset = asset;
      w.rate_min_in = rmin[15:0];
      w.rate_max_in = rmax[15:0];
      word_q.push_back(w);
   endtask

   task automatic add_point(input logic [31:0] seed, input bit first);
      hwps_pkg::req_word_type w;
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      w = noise[$bits(hwps_pkg::req_word_type)-1:0];
      w.kind = KIND_POINT;
      w.pt_seed = seed;
      w.first_of_batch = first;
      word_q.push_back(w);
   endtask

   task automatic add_random_load();
      int wgt;
      int rmin;
      int rmax;
      case ($urandom_range(3))
         0: wgt = 0;
         1: wgt = $urandom_range(1, 10);
         default: wgt = $urandom_range(65535);
      endcase
      rmin = ($urandom_range(3) == 0) ? $urandom_range(5) : $urandom_range(65535);
      case ($urandom_range(3))
         0: rmax = rmin;
         1: rmax = rmin + $urandom_range(600);
         default: rmax = $urandom_range(65535);
      endcase
      add_load($urandom_range(15), wgt, $urandom_range(4) != 0, rmin, rmax);
   endtask

   // mostly points over a live pool, with reloads and the odd emptied pool
   task automatic random_phase(input int n);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(39))
            0: for (int i = 0; i < DEPTH; i++) add_load(i, 0, $urandom_range(1), 0, 0);
            1, 2, 3, 4, 5, 6, 7, 8, 9, 10: add_random_load();
            default: add_point($urandom, $urandom_range(9) == 0);
         endcase
      end
   endtask

   initial begin
      logic [31:0] seeds[5];
      logic [31:0] caps[5];
      int          idles[5];
      for (int i = 0; i < DEPTH; i++) begin
         sh_weight[i] = '0;
         sh_asset[i]  = 1'b0;
         sh_rmin[i]   = '0;
         sh_rmax[i]   = '0;
      end
      sh_seen = '0;
      sh_seed = '0;
      sh_cap  = hwps_pkg::HARD_CAP;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pool, field extremes, skipped slots, rate corners
      add_point(32'h0, 1'b1);
      add_load(0, 65535, 1'b1, 0, 0);
      add_point(32'h0, 1'b0);
      add_point(32'h7FFF_FFFF, 1'b0);
      add_point(32'h8000_0000, 1'b0);
      add_point(32'hFFFF_FFFF, 1'b0);
      add_load(15, 1, 1'b1, 65535, 65535);
      add_load(5, 100, 1'b0, 10, 900);
      add_load(6, 0, 1'b1, 10, 900);
      add_load(3, 300, 1'b1, 2, 65535);
      for (int i = 0; i < 4; i++) add_point($urandom, 1'b0);
      add_load(0, 0, 1'b1, 0, 0);
      for (int i = 0; i < 3; i++) add_point($urandom, 1'b0);
      add_load(3, 300, 1'b1, 1000, 10);
      for (int i = 0; i < 3; i++) add_point($urandom, 1'b0);
      wait_idle();

      // unknown register indexes must be ignored
      write_csr(2'd2, $urandom);
      write_csr(2'd3, $urandom);

      seeds = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, $urandom};
      caps  = '{32'd3, 32'd0, 32'd100000, 32'd131071, $urandom_range(20)};
      idles = '{0, 71, 23, 0, 71};
      for (int p = 0; p < 5; p++) begin
         write_csr(hwps_pkg::CSR_GLOBAL_SEED, seeds[p]);
         write_csr(hwps_pkg::CSR_POINT_CAP, caps[p]);
         idle_pct = idles[p];
         random_phase(220);
      end

      // cap zero flags every point, then a raised cap decorates the same batch
      write_csr(hwps_pkg::CSR_POINT_CAP, 32'd0);
      idle_pct = 0;
      add_load(1, 5, 1'b1, 0, 40);
      add_point($urandom, 1'b1);
      for (int i = 0; i < 10; i++) add_point($urandom, 1'b0);
      write_csr(hwps_pkg::CSR_POINT_CAP, 32'd100000);
      for (int i = 0; i < 10; i++) add_point($urandom, 1'b0);
      add_point($urandom, 1'b1);

      wait_idle();
      if (errors == 0 && sample_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/hwps_pkg.sv
rtl/hwps_ctrl.sv
rtl/hwps_dp.sv
rtl/hashed_weighted_pool_sampler.sv
tb/tb.sv
